>>> rtl/rid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rid_pkg
// Shared constants for the restoring integer divider.
// ----------------------------------------------------------------------------
package rid_pkg;

   // default operand width
   localparam int RID_WIDTH = 32;

endpackage

>>> rtl/rid_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rid_req_if / rid_rsp_if
// Valid/ready channels carrying division requests and results.
// ----------------------------------------------------------------------------
interface rid_req_if
   import rid_pkg::*;
#(
   parameter int WIDTH = RID_WIDTH
);
   logic             valid;
   logic             ready;
   logic             req_type;
   logic [WIDTH-1:0] dividend;
   logic [WIDTH-1:0] divisor;

   modport source (output valid, output req_type, output dividend, output divisor,
                   input ready);
   modport sink   (input valid, input req_type, input dividend, input divisor,
                   output ready);
endinterface

interface rid_rsp_if
   import rid_pkg::*;
#(
   parameter int WIDTH = RID_WIDTH
);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] quotient;
   logic [WIDTH-1:0] remainder;

   modport source (output valid, output quotient, output remainder, input ready);
   modport sink   (input valid, input quotient, input remainder, output ready);
endinterface

>>> rtl/rid_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rid_step
// One restoring shift-subtract step: shifts the next dividend bit into the
// partial remainder and subtracts the divisor when it fits.
// ----------------------------------------------------------------------------
module rid_step
   import rid_pkg::*;
#(
   parameter int WIDTH = RID_WIDTH
) (
   input  logic [WIDTH-1:0] rem_i,
   input  logic             next_bit,
   input  logic [WIDTH-1:0] divisor,
   output logic [WIDTH-1:0] rem_o,
   output logic             quo_bit
);

   logic [WIDTH:0]   partial;
   logic [WIDTH+1:0] diff;

   assign partial = {rem_i, next_bit};
   // extra top bit acts as the borrow out
   assign diff    = {1'b0, partial} - {2'b00, divisor};
   assign quo_bit = ~diff[WIDTH+1];
   assign rem_o   = quo_bit ? diff[WIDTH-1:0] : partial[WIDTH-1:0];

endmodule

>>> rtl/rid_negate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rid_negate
// Conditional two's complement negation, used for operand magnitudes and
// for the sign fix-up of the results.
// ----------------------------------------------------------------------------
module rid_negate
   import rid_pkg::*;
#(
   parameter int WIDTH = RID_WIDTH
) (
   input  logic [WIDTH-1:0] value_i,
   input  logic             negate,
   output logic [WIDTH-1:0] value_o
);

   assign value_o = negate ? (~value_i + {{(WIDTH-1){1'b0}}, 1'b1}) : value_i;

endmodule

>>> rtl/restoring_int_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// restoring_int_divider
// Signed/unsigned integer divider returning quotient and remainder, one
// quotient bit per cycle through a shared restoring shift-subtract step.
//
//   channel   direction  handshake     payload
//   req_bus   in         valid/ready   req_type, dividend, divisor
//   rsp_bus   out        valid/ready   quotient, remainder
//
// An accepted transaction passes through ST_PREP (operand magnitudes), ST_DIV
// (the one-bit-per-cycle shift-subtract step) and ST_FIX (the sign fix-up)
// before rsp_bus.valid rises; a zero divisor skips the step.
// req_bus.ready is high only while idle, so one transaction is in flight.
// The result is held until taken; the divider is ready again the cycle after.
// Reset is synchronous and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module restoring_int_divider
   import rid_pkg::*;
#(
   parameter int WIDTH = RID_WIDTH
) (
   input  logic   clock,
   input  logic   reset,
   rid_req_if.sink   req_bus,
   rid_rsp_if.source rsp_bus
);

   localparam int CNT_W = $clog2(WIDTH);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_PREP = 5'b00010,
      ST_DIV  = 5'b00100,
      ST_FIX  = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] div_ff, div_in;
   logic             signed_ff, signed_in;
   logic             xneg_ff, xneg_in;
   logic             yneg_ff, yneg_in;

   logic [WIDTH-1:0] neg0_in_val, neg0_out;
   logic [WIDTH-1:0] neg1_in_val, neg1_out;
   logic             neg0_en, neg1_en;
   logic [WIDTH-1:0] step_rem;
   logic             step_bit;
   logic             req_fire;

   assign req_fire = req_bus.valid & req_bus.ready;

   // the two negators serve operand magnitudes first, then the result signs
   always_comb begin
      if (state_ff == ST_FIX) begin
         neg0_in_val = quo_ff;
         neg0_en     = signed_ff & (xneg_ff ^ yneg_ff);
         neg1_in_val = rem_ff;
         neg1_en     = signed_ff & xneg_ff;
      end else begin
         neg0_in_val = quo_ff;
         neg0_en     = xneg_ff;
         neg1_in_val = div_ff;
         neg1_en     = yneg_ff;
      end
   end

   rid_negate #(.WIDTH(WIDTH)) u_neg0 (
      .value_i (neg0_in_val),
      .negate  (neg0_en),
      .value_o (neg0_out)
   );

   rid_negate #(.WIDTH(WIDTH)) u_neg1 (
      .value_i (neg1_in_val),
      .negate  (neg1_en),
      .value_o (neg1_out)
   );

   rid_step #(.WIDTH(WIDTH)) u_step (
      .rem_i    (rem_ff),
      .next_bit (quo_ff[WIDTH-1]),
      .divisor  (div_ff),
      .rem_o    (step_rem),
      .quo_bit  (step_bit)
   );

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      div_in    = div_ff;
      signed_in = signed_ff;
      xneg_in   = xneg_ff;
      yneg_in   = yneg_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               quo_in    = req_bus.dividend;
               div_in    = req_bus.divisor;
               signed_in = req_bus.req_type;
               xneg_in   = req_bus.req_type & req_bus.dividend[WIDTH-1];
               yneg_in   = req_bus.req_type & req_bus.divisor[WIDTH-1];
               state_in  = ST_PREP;
            end
         end
         ST_PREP: begin
            div_in = neg1_out;
            cnt_in = CNT_W'(WIDTH - 1);
            if (neg1_out == '0) begin
               // divide by zero: quotient one (zero for an unsigned zero dividend)
               quo_in   = {{(WIDTH-1){1'b0}}, signed_ff | (neg0_out != '0)};
               rem_in   = neg0_out;
               state_in = ST_FIX;
            end else begin
               quo_in   = neg0_out;
               rem_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // dividend bits leave the top as quotient bits enter the bottom
            quo_in = {quo_ff[WIDTH-2:0], step_bit};
            rem_in = step_rem;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            quo_in   = neg0_out;
            rem_in   = neg1_out;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_bus.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      div_ff    <= div_in;
      signed_ff <= signed_in;
      xneg_ff   <= xneg_in;
      yneg_ff   <= yneg_in;
   end

   assign req_bus.ready     = (state_ff == ST_IDLE);
   assign rsp_bus.valid     = (state_ff == ST_DONE);
   assign rsp_bus.quotient  = quo_ff;
   assign rsp_bus.remainder = rem_ff;

endmodule
